### design/codm_pkg.sv
// shared types, codes and constants of the cell overlap density map
// no dependencies; codm_div and cell_overlap_density_map import this package
`default_nettype none

package codm_pkg;

    // widths fixed by the request and register fields
    localparam int CW        = 36;   // signed coordinate arithmetic width
    localparam int SUM_W     = 48;   // bin area sum width
    localparam int PITCH_W   = 20;   // bin pitch width
    localparam int DEN_W     = 40;   // divider denominator width (bin area)
    localparam int CFG_IDX_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // request types
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // cell kinds and filter codes
    localparam logic [1:0] KIND_MACRO = 2'd0;
    localparam logic [1:0] KIND_STD   = 2'd1;
    localparam logic [1:0] FILT_ALL   = 2'd0;
    localparam logic [1:0] FILT_MACRO = 2'd1;
    localparam logic [1:0] FILT_STD   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DWAIT,
        S_SETUP,
        S_ROW,
        S_CALC,
        S_MUL,
        S_WR,
        S_RD_ADDR,
        S_RD_AREA,
        S_RD_MUL,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        DS_COLS,
        DS_ROWS,
        DS_C0,
        DS_C1,
        DS_R0,
        DS_R1,
        DS_DENS
    } div_sel_t;

    typedef struct packed {
        logic start;
        logic long_mode;
    } div_req_t;

    function automatic logic signed [CW-1:0] sx32(input logic [31:0] v);
        sx32 = {{(CW-32){v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

### design/codm_req_if.sv
// request channel of the density map: valid/ready plus the request fields
// no dependencies
`default_nettype none

interface codm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] cell_left;
    logic signed [31:0] cell_bottom;
    logic [30:0]        cell_width;
    logic [30:0]        cell_height;
    logic [1:0]         cell_kind;
    logic [5:0]         bin_row;
    logic [5:0]         bin_col;

    modport source(output valid, req_type, cell_left, cell_bottom, cell_width,
                   cell_height, cell_kind, bin_row, bin_col, input ready);
    modport sink(input valid, req_type, cell_left, cell_bottom, cell_width,
                 cell_height, cell_kind, bin_row, bin_col, output ready);
endinterface

`default_nettype wire

### design/codm_rsp_if.sv
// result channel of the density map: valid/ready plus the result fields
// no dependencies
`default_nettype none

interface codm_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] density;
    logic        bin_valid;
    logic        req_done;

    modport source(output valid, density, bin_valid, req_done, input ready);
    modport sink(input valid, density, bin_valid, req_done, output ready);
endinterface

`default_nettype wire

### design/codm_cfg_if.sv
// configuration write channel: valid/ready, register index and write data
// no dependencies
`default_nettype none

interface codm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/codm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module codm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

### design/codm_div.sv
// restoring radix-2 unsigned divider, one quotient bit per cycle
// depends on codm_pkg (div_req_t)
`default_nettype none

module codm_div #(
    parameter int NW      = 64,
    parameter int DW      = 40,
    parameter int SHORT_W = 36
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire codm_pkg::div_req_t dreq,
    input  wire logic [NW-1:0]      num,
    input  wire logic [DW-1:0]      den,
    output logic      [NW-1:0]      quo,
    output logic                    done
);
    import codm_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    n_reg;
    logic [DW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic             ge;
    logic [DW:0]      rem_sub;

    assign rem_sh  = {rem_reg, n_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign rem_sub = rem_sh - {1'b0, den};
    assign quo     = n_reg;
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (dreq.start)
        begin
            cnt_reg  <= dreq.long_mode ? CNT_W'(NW) : CNT_W'(SHORT_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dreq.start)
        begin
            n_reg   <= dreq.long_mode ? num : {num[SHORT_W-1:0], {(NW-SHORT_W){1'b0}}};
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            n_reg   <= {n_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end
endmodule

`default_nettype wire

### design/cell_overlap_density_map.sv
// placement bin density map: request sequencer, bin sum ram and shared divider
// depends on codm_pkg, codm_req_if, codm_rsp_if, codm_cfg_if, codm_ram, codm_div
//
// usage
//   req carries one request at a time: add a cell rectangle, read one bin, or
//   clear all bins; rsp returns exactly one result per request
//   cfg writes the region bounds, bin pitch and kind filter; cfg.ready is
//   always high; the user must let writes go in only while no request is
//   in flight, as the block itself does not enforce this
// sequencing, one request at a time (req.ready is high only when idle)
//   add: six grid/corner divisions, then a row step per covered row and,
//     per covered bin, ram read, area multiply and saturating write back
//   read: two divisions, address and area setup, then one 48+FRAC_BITS bit
//     division of the scaled sum by the bin area
//   clear: one ram write per bin
//   the divisions run in turn on the shared one-bit-per-cycle divider
// reset
//   the ram is swept to zero after reset with req.ready low; configuration
//   writes are taken during the sweep
// stall
//   a finished result sits in the output register until rsp.ready; a later
//   result waits in its final state until the register is free
`default_nettype none

module cell_overlap_density_map #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    codm_req_if.sink  req,
    codm_rsp_if.source rsp,
    codm_cfg_if.sink  cfg
);
    import codm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
    localparam int NW    = SUM_W + FRAC_BITS;

    // configuration registers
    logic [31:0]        left_reg, bottom_reg, right_reg, top_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [1:0]         filter_reg;

    // control
    state_t   state_reg, state_next;
    div_sel_t sel_reg;
    logic     out_valid_reg;
    logic [AW-1:0] clr_addr_reg;
    logic     clr_resp_reg;

    // latched request
    logic signed [CW-1:0] cl_reg, cb_reg, cr_reg, ct_reg;
    logic [5:0] row_reg, col_reg;
    logic       is_read_reg;

    // grid and walk state
    logic [CNT_W-1:0] cols_reg, rows_reg, c0_reg, c1_reg, r0_reg, r1_reg;
    logic             c1_neg_reg, r1_neg_reg;
    logic [CNT_W-1:0] r_reg, c_reg;
    logic signed [CW-1:0] bx0_reg, by0_reg, bx_start_reg;
    logic [AW-1:0]        rowbase_reg;
    logic [PITCH_W-1:0]   ow_reg, oh_reg;
    logic                 ow_pos_reg;
    logic [DEN_W-1:0]     prod_reg;
    logic [SUM_W-1:0]     sum_reg;

    // result staging and output registers
    logic [31:0] res_density_reg, density_out_reg;
    logic        res_valid_reg, valid_out_reg;
    logic        res_done_reg, done_out_reg;

    // derived values
    logic [PITCH_W-1:0]   pitch;
    logic signed [CW-1:0] pitch_s, left_s, bottom_s, right_s, top_s;
    logic signed [CW-1:0] span_x, span_y, ax0, ax1, ay0, ay1;
    logic signed [CW-1:0] num_short;
    logic signed [CW-1:0] bx1, by1, ow, oh, ow_lo, ow_hi, oh_lo, oh_hi;
    logic [CW-1:0]        xoff, yoff, rd_xoff, rd_yoff;
    logic                 kind_pass, clr_last, last_row, c_last, add_empty, rd_in_grid;
    logic                 resp_load;
    logic [CNT_W-1:0]     q_cols, q_rows, q_c1, q_r1;
    logic [48:0]          sat_sum;

    // ram and divider signals
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr, walk_addr;
    logic [SUM_W-1:0]  ram_wdata, ram_rdata;
    div_req_t          dreq;
    logic [NW-1:0]     div_num, div_quo;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;

    // zero pitch behaves as one
    assign pitch    = (pitch_reg == '0) ? PITCH_W'(1) : pitch_reg;
    assign pitch_s  = $signed({{(CW-PITCH_W){1'b0}}, pitch});
    assign left_s   = sx32(left_reg);
    assign bottom_s = sx32(bottom_reg);
    assign right_s  = sx32(right_reg);
    assign top_s    = sx32(top_reg);

    assign span_x = right_s - left_s;
    assign span_y = top_s - bottom_s;
    assign ax0    = cl_reg - left_s;
    assign ax1    = cr_reg - left_s;
    assign ay0    = cb_reg - bottom_s;
    assign ay1    = ct_reg - bottom_s;

    // numerator for the short divisions: ceil for grid size, floor for corners
    always_comb
    begin
        num_short = '0;
        case (sel_reg)
            DS_COLS: num_short = (span_x > 0) ? span_x + pitch_s - 1 : '0;
            DS_ROWS: num_short = (span_y > 0) ? span_y + pitch_s - 1 : '0;
            DS_C0:   num_short = (ax0 < 0) ? '0 : ax0;
            DS_C1:   num_short = (ax1 < 0) ? '0 : ax1;
            DS_R0:   num_short = (ay0 < 0) ? '0 : ay0;
            DS_R1:   num_short = (ay1 < 0) ? '0 : ay1;
            default: num_short = '0;
        endcase
    end

    assign div_num = (sel_reg == DS_DENS) ? {sum_reg, {FRAC_BITS{1'b0}}}
                                          : NW'($unsigned(num_short));
    assign div_den = (sel_reg == DS_DENS) ? prod_reg : DEN_W'(pitch);

    // quotient clamps
    assign q_cols = (div_quo > NW'(MAX_COLS)) ? CNT_W'(MAX_COLS) : div_quo[CNT_W-1:0];
    assign q_rows = (div_quo > NW'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : div_quo[CNT_W-1:0];
    assign q_c1   = (div_quo >= NW'(cols_reg)) ? cols_reg - CNT_W'(1) : div_quo[CNT_W-1:0];
    assign q_r1   = (div_quo >= NW'(rows_reg)) ? rows_reg - CNT_W'(1) : div_quo[CNT_W-1:0];

    assign rd_in_grid = (row_reg < q_rows) && (col_reg < cols_reg);

    assign kind_pass = (filter_reg == FILT_ALL) ||
                       ((filter_reg == FILT_MACRO) && (req.cell_kind == KIND_MACRO)) ||
                       ((filter_reg == FILT_STD) && (req.cell_kind == KIND_STD));

    assign add_empty = (cols_reg == '0) || (rows_reg == '0) || c1_neg_reg || r1_neg_reg ||
                       (c0_reg > c1_reg) || (r0_reg > r1_reg);

    assign clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign last_row = (r_reg == r1_reg);
    assign c_last   = (c_reg == c1_reg);

    // bin edges, clipped by the region bound, and overlap extents
    assign bx1   = (bx0_reg + pitch_s < right_s) ? bx0_reg + pitch_s : right_s;
    assign by1   = (by0_reg + pitch_s < top_s) ? by0_reg + pitch_s : top_s;
    assign ow_hi = (cr_reg < bx1) ? cr_reg : bx1;
    assign ow_lo = (cl_reg > bx0_reg) ? cl_reg : bx0_reg;
    assign oh_hi = (ct_reg < by1) ? ct_reg : by1;
    assign oh_lo = (cb_reg > by0_reg) ? cb_reg : by0_reg;
    assign ow    = ow_hi - ow_lo;
    assign oh    = oh_hi - oh_lo;

    assign xoff    = CW'(c0_reg) * CW'(pitch);
    assign yoff    = CW'(r0_reg) * CW'(pitch);
    assign rd_xoff = CW'(col_reg) * CW'(pitch);
    assign rd_yoff = CW'(row_reg) * CW'(pitch);

    assign walk_addr = rowbase_reg + AW'(c_reg);

    // saturating accumulate
    assign sat_sum = {1'b0, ram_rdata} + 49'(prod_reg);

    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.req_type)
                        REQ_ADD:   state_next = kind_pass ? S_DIV : S_RESP;
                        REQ_READ:  state_next = S_DIV;
                        REQ_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_DIV:
                state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    unique case (sel_reg)
                        DS_ROWS:
                        begin
                            if (!is_read_reg)
                                state_next = S_DIV;
                            else
                                state_next = rd_in_grid ? S_RD_ADDR : S_RESP;
                        end
                        DS_R1:   state_next = S_SETUP;
                        DS_DENS: state_next = S_RESP;
                        default: state_next = S_DIV;
                    endcase
                end
            end
            S_SETUP:
                state_next = add_empty ? S_RESP : S_ROW;
            S_ROW:
            begin
                if (oh > 0)
                    state_next = S_CALC;
                else if (last_row)
                    state_next = S_RESP;
            end
            S_CALC:
                state_next = S_MUL;
            S_MUL:
                state_next = S_WR;
            S_WR:
            begin
                if (!c_last)
                    state_next = S_CALC;
                else
                    state_next = last_row ? S_RESP : S_ROW;
            end
            S_RD_ADDR:
                state_next = S_RD_AREA;
            S_RD_AREA:
                state_next = S_RD_MUL;
            S_RD_MUL:
                state_next = S_DIV;
            S_RESP:
            begin
                if (resp_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready      = (state_reg == S_IDLE);
        dreq.start     = (state_reg == S_DIV);
        dreq.long_mode = (sel_reg == DS_DENS);
        ram_re         = 1'b0;
        ram_raddr      = walk_addr;
        ram_we         = 1'b0;
        ram_waddr      = walk_addr;
        ram_wdata      = (sat_sum >= 49'(SUM_MAX)) ? SUM_MAX : sat_sum[SUM_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            S_CALC:
                ram_re = 1'b1;
            S_WR:
                ram_we = ow_pos_reg;
            S_RD_ADDR:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(int'(row_reg) * MAX_COLS + int'(col_reg));
            end
            default:
            begin
            end
        endcase
    end

    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.density   = density_out_reg;
    assign rsp.bin_valid = valid_out_reg;
    assign rsp.req_done  = done_out_reg;

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            left_reg      <= '0;
            bottom_reg    <= '0;
            right_reg     <= '0;
            top_reg       <= '0;
            pitch_reg     <= PITCH_W'(1);
            filter_reg    <= FILT_ALL;
        end
        else
        begin
            state_reg <= state_next;
            if (resp_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_last)
                    clr_resp_reg <= 1'b0;
            end
            else if ((state_reg == S_IDLE) && req.valid && (req.req_type == REQ_CLEAR))
            begin
                clr_addr_reg <= '0;
                clr_resp_reg <= 1'b1;
            end

            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_LEFT:   left_reg   <= cfg.data;
                    CFG_BOTTOM: bottom_reg <= cfg.data;
                    CFG_RIGHT:  right_reg  <= cfg.data;
                    CFG_TOP:    top_reg    <= cfg.data;
                    CFG_PITCH:  pitch_reg  <= cfg.data[PITCH_W-1:0];
                    CFG_FILTER: filter_reg <= cfg.data[1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (resp_load)
        begin
            density_out_reg <= res_density_reg;
            valid_out_reg   <= res_valid_reg;
            done_out_reg    <= res_done_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cl_reg  <= sx32(req.cell_left);
                    cb_reg  <= sx32(req.cell_bottom);
                    cr_reg  <= sx32(req.cell_left) +
                               $signed({{(CW-31){1'b0}}, req.cell_width});
                    ct_reg  <= sx32(req.cell_bottom) +
                               $signed({{(CW-31){1'b0}}, req.cell_height});
                    row_reg <= req.bin_row;
                    col_reg <= req.bin_col;
                    is_read_reg     <= (req.req_type == REQ_READ);
                    sel_reg         <= DS_COLS;
                    res_density_reg <= '0;
                    res_valid_reg   <= 1'b0;
                    res_done_reg    <= (req.req_type == REQ_ADD) ||
                                       (req.req_type == REQ_READ) ||
                                       (req.req_type == REQ_CLEAR);
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        DS_COLS:
                        begin
                            cols_reg <= q_cols;
                            sel_reg  <= DS_ROWS;
                        end
                        DS_ROWS:
                        begin
                            rows_reg      <= q_rows;
                            res_valid_reg <= is_read_reg && rd_in_grid;
                            sel_reg       <= DS_C0;
                        end
                        DS_C0:
                        begin
                            c0_reg  <= q_cols;
                            sel_reg <= DS_C1;
                        end
                        DS_C1:
                        begin
                            c1_reg     <= q_c1;
                            c1_neg_reg <= (ax1 < 0);
                            sel_reg    <= DS_R0;
                        end
                        DS_R0:
                        begin
                            r0_reg  <= q_rows;
                            sel_reg <= DS_R1;
                        end
                        DS_R1:
                        begin
                            r1_reg     <= q_r1;
                            r1_neg_reg <= (ay1 < 0);
                        end
                        default:
                        begin
                            // saturate the scaled quotient to 32 bits
                            res_density_reg <= (|div_quo[NW-1:32]) ? 32'hFFFF_FFFF
                                                                    : div_quo[31:0];
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                r_reg        <= r0_reg;
                by0_reg      <= bottom_s + $signed(yoff);
                bx_start_reg <= left_s + $signed(xoff);
                rowbase_reg  <= AW'(int'(r0_reg) * MAX_COLS);
            end
            S_ROW:
            begin
                oh_reg  <= oh[PITCH_W-1:0];
                bx0_reg <= bx_start_reg;
                c_reg   <= c0_reg;
                if (!(oh > 0) && !last_row)
                begin
                    r_reg       <= r_reg + CNT_W'(1);
                    by0_reg     <= by0_reg + pitch_s;
                    rowbase_reg <= rowbase_reg + AW'(MAX_COLS);
                end
            end
            S_CALC:
            begin
                ow_reg     <= ow[PITCH_W-1:0];
                ow_pos_reg <= (ow > 0);
            end
            S_MUL:
                prod_reg <= DEN_W'(ow_reg) * DEN_W'(oh_reg);
            S_WR:
            begin
                if (!c_last)
                begin
                    c_reg   <= c_reg + CNT_W'(1);
                    bx0_reg <= bx0_reg + pitch_s;
                end
                else if (!last_row)
                begin
                    r_reg       <= r_reg + CNT_W'(1);
                    by0_reg     <= by0_reg + pitch_s;
                    rowbase_reg <= rowbase_reg + AW'(MAX_COLS);
                end
            end
            S_RD_ADDR:
            begin
                bx0_reg <= left_s + $signed(rd_xoff);
                by0_reg <= bottom_s + $signed(rd_yoff);
            end
            S_RD_AREA:
            begin
                sum_reg <= ram_rdata;
                ow_reg  <= PITCH_W'(bx1 - bx0_reg);
                oh_reg  <= PITCH_W'(by1 - by0_reg);
            end
            S_RD_MUL:
            begin
                prod_reg <= DEN_W'(ow_reg) * DEN_W'(oh_reg);
                sel_reg  <= DS_DENS;
            end
            default:
            begin
            end
        endcase
    end

    codm_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_sum_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    codm_div #(
        .NW     (NW),
        .DW     (DEN_W),
        .SHORT_W(CW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .dreq (dreq),
        .num  (div_num),
        .den  (div_den),
        .quo  (div_quo),
        .done (div_done)
    );
endmodule

`default_nettype wire

### dv/cell_overlap_density_map_test.sv
// testbench for cell_overlap_density_map: a cycle-free predictor of the bin map
// checks every result; depends on codm_pkg and the codm_req/rsp/cfg interfaces
`default_nettype none

module cell_overlap_density_map_test;
    timeunit 1ns;
    timeprecision 1ps;
    import codm_pkg::*;

    localparam int  ROWS      = 64;
    localparam int  COLS      = 64;
    localparam int  FRAC      = 16;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint SUM_TOP = (64'd1 << 48) - 1;

    typedef struct {
        logic [1:0]         kind_of_req;
        logic signed [31:0] left;
        logic signed [31:0] bottom;
        logic [30:0]        width;
        logic [30:0]        height;
        logic [1:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
    } density_req_t;

    typedef struct {
        logic [31:0] density;
        logic        bin_valid;
        logic        req_done;
    } density_rsp_t;

    logic clk;
    logic rst_n;

    codm_req_if req();
    codm_rsp_if rsp();
    codm_cfg_if cfg();

    cell_overlap_density_map u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // shadow of the configuration registers and of the bin area store
    longint  reg_left, reg_bottom, reg_right, reg_top, reg_pitch, reg_filter;
    logic [47:0] area_store [ROWS*COLS];

    density_req_t pending_reqs[$];
    density_rsp_t expected_rsps[$];

    int     errors;
    int     n_adds, n_reads, n_clears, n_odd, n_checked;
    longint cycle_count;
    bit     idle_on;
    int     hold_asks, hold_served;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic longint pitch_eff();
        return (reg_pitch == 0) ? 64'd1 : reg_pitch;
    endfunction

    // floor division, the divisor is always positive here
    function automatic longint div_floor(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint bins_along(longint lo, longint hi, longint p, longint lim);
        longint span;
        longint n;
        span = hi - lo;
        if (span <= 0)
            return 0;
        n = (span + p - 1) / p;
        return (n > lim) ? lim : n;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic void deposit_cell(density_req_t it);
        longint p, cols, rows, cl, cb, cr, ct, c0, c1, r0, r1;
        longint by0, by1, bx0, bx1, oh, ow;
        longint unsigned add_area, cur;
        p    = pitch_eff();
        cols = bins_along(reg_left, reg_right, p, COLS);
        rows = bins_along(reg_bottom, reg_top, p, ROWS);
        cl = longint'(it.left);
        cb = longint'(it.bottom);
        cr = cl + longint'({1'b0, it.width});
        ct = cb + longint'({1'b0, it.height});
        c0 = lmax(0, div_floor(cl - reg_left, p));
        c1 = lmin(cols - 1, div_floor(cr - reg_left, p));
        r0 = lmax(0, div_floor(cb - reg_bottom, p));
        r1 = lmin(rows - 1, div_floor(ct - reg_bottom, p));
        for (longint r = r0; r <= r1; r++)
        begin
            by0 = reg_bottom + r * p;
            by1 = lmin(by0 + p, reg_top);
            oh  = lmin(ct, by1) - lmax(cb, by0);
            if (oh > 0)
            begin
                for (longint c = c0; c <= c1; c++)
                begin
                    bx0 = reg_left + c * p;
                    bx1 = lmin(bx0 + p, reg_right);
                    ow  = lmin(cr, bx1) - lmax(cl, bx0);
                    if (ow > 0)
                    begin
                        add_area = longint'(ow) * longint'(oh);
                        cur = area_store[r*COLS + c];
                        // bin sums saturate at the top of 48 bits
                        if (add_area >= SUM_TOP - cur)
                            area_store[r*COLS + c] = SUM_TOP[47:0];
                        else
                            area_store[r*COLS + c] = cur + add_area;
                    end
                end
            end
        end
    endfunction

    function automatic density_rsp_t bin_density(logic [5:0] row, logic [5:0] col);
        density_rsp_t res;
        longint p, cols, rows, bx0, by0, bx1, by1;
        longint unsigned area, total, q, rem, frac;
        res = '{density: 0, bin_valid: 0, req_done: 1};
        p    = pitch_eff();
        cols = bins_along(reg_left, reg_right, p, COLS);
        rows = bins_along(reg_bottom, reg_top, p, ROWS);
        if (longint'(row) >= rows || longint'(col) >= cols)
            return res;
        res.bin_valid = 1;
        bx0 = reg_left + longint'(col) * p;
        by0 = reg_bottom + longint'(row) * p;
        bx1 = lmin(bx0 + p, reg_right);
        by1 = lmin(by0 + p, reg_top);
        area  = longint'(bx1 - bx0) * longint'(by1 - by0);
        total = area_store[row*COLS + col];
        q   = total / area;
        rem = total % area;
        if (q > (64'hFFFF_FFFF >> FRAC))
            res.density = 32'hFFFF_FFFF;
        else
        begin
            frac = (rem << FRAC) / area;
            q = (q << FRAC) + frac;
            res.density = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end
        return res;
    endfunction

    // expected result of one accepted request, updating the shadow store
    function automatic density_rsp_t apply_request(density_req_t it);
        density_rsp_t res;
        bit pass;
        res = '{density: 0, bin_valid: 0, req_done: 0};
        case (it.kind_of_req)
            REQ_ADD:
            begin
                pass = (reg_filter == FILT_ALL)
                    || (reg_filter == FILT_MACRO && it.kind == KIND_MACRO)
                    || (reg_filter == FILT_STD && it.kind == KIND_STD);
                if (pass)
                    deposit_cell(it);
                res.req_done = 1;
                n_adds++;
            end
            REQ_READ:
            begin
                res = bin_density(it.row, it.col);
                n_reads++;
            end
            REQ_CLEAR:
            begin
                foreach (area_store[i])
                    area_store[i] = '0;
                res.req_done = 1;
                n_clears++;
            end
            default:
                n_odd++;    // unknown type leaves everything alone
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // request driver: one request in flight on the wire, random gaps
    // ---------------------------------------------------------------
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
            end
            // a request on the wire holds until it is taken
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (idle_on && pending_reqs.size() > 0 && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 8) - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req.valid       <= 1'b1;
                    req.req_type    <= pending_reqs[0].kind_of_req;
                    req.cell_left   <= pending_reqs[0].left;
                    req.cell_bottom <= pending_reqs[0].bottom;
                    req.cell_width  <= pending_reqs[0].width;
                    req.cell_height <= pending_reqs[0].height;
                    req.cell_kind   <= pending_reqs[0].kind;
                    req.bin_row     <= pending_reqs[0].row;
                    req.bin_col     <= pending_reqs[0].col;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor with random stalls and the long hold-off
    // ---------------------------------------------------------------
    int stall_left;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got 0x%0h want 0x%0h (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        density_rsp_t want;
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected result density", rsp.density, 0);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.density !== want.density)
                        report_mismatch("density", rsp.density, want.density);
                    if (rsp.bin_valid !== want.bin_valid)
                        report_mismatch("bin_valid", rsp.bin_valid, want.bin_valid);
                    if (rsp.req_done !== want.req_done)
                        report_mismatch("req_done", rsp.req_done, want.req_done);
                end
                n_checked++;
            end
            if (hold_served != hold_asks)
            begin
                // long hold-off so the block fills and drops req.ready
                hold_served++;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_rsps.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned span;
        span = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic longint clamp32(longint v);
        return lmax(I32_MIN, lmin(I32_MAX, v));
    endfunction

    function automatic density_req_t cell_req(longint l, longint b, longint w, longint h,
                                              int kind);
        density_req_t it;
        it.kind_of_req = REQ_ADD;
        it.left   = l[31:0];
        it.bottom = b[31:0];
        it.width  = w[30:0];
        it.height = h[30:0];
        it.kind   = kind[1:0];
        it.row    = $urandom;
        it.col    = $urandom;
        return it;
    endfunction

    function automatic density_req_t read_req(int row, int col);
        density_req_t it;
        it = cell_req($urandom, $urandom, $urandom, $urandom, $urandom);
        it.kind_of_req = REQ_READ;
        it.row = row[5:0];
        it.col = col[5:0];
        return it;
    endfunction

    function automatic density_req_t plain_req(logic [1:0] kind_of_req);
        density_req_t it;
        it = read_req($urandom, $urandom);
        it.kind_of_req = kind_of_req;
        return it;
    endfunction

    // random request shaped around the current region
    function automatic density_req_t random_req();
        longint p, sx, sy, l, b;
        int sel;
        density_req_t it;
        p  = pitch_eff();
        sx = lmax(reg_right - reg_left, p);
        sy = lmax(reg_top - reg_bottom, p);
        sel = $urandom_range(0, 99);
        if (sel < 68)
        begin
            l = clamp32(pick_between(reg_left - 2*p, reg_left + sx + p));
            b = clamp32(pick_between(reg_bottom - 2*p, reg_bottom + sy + p));
            it = cell_req(l, b, lmin(I32_MAX, pick_between(0, 3*p)),
                          lmin(I32_MAX, pick_between(0, 3*p)), $urandom_range(0, 3));
        end
        else if (sel < 92)
            it = read_req($urandom_range(0, 63), $urandom_range(0, 63));
        else if (sel < 94)
            it = plain_req(REQ_CLEAR);
        else if (sel < 96)
            it = plain_req(2'd3);
        else
        begin
            // raw fields so every input bit toggles
            it = cell_req($urandom, $urandom, $urandom, $urandom, $urandom);
            it.kind_of_req = $urandom_range(0, 1) ? REQ_ADD : REQ_READ;
        end
        return it;
    endfunction

    task automatic push_req(density_req_t it);
        @(negedge clk);
        pending_reqs.push_back(it);
    endtask

    task automatic push_random(int count);
        repeat (count)
            push_req(random_req());
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        @(posedge clk);
        cfg.index <= idx;
        cfg.data  <= value[31:0];
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_LEFT:   reg_left   = longint'($signed(value[31:0]));
            CFG_BOTTOM: reg_bottom = longint'($signed(value[31:0]));
            CFG_RIGHT:  reg_right  = longint'($signed(value[31:0]));
            CFG_TOP:    reg_top    = longint'($signed(value[31:0]));
            CFG_PITCH:  reg_pitch  = value & 64'hF_FFFF;
            CFG_FILTER: reg_filter = value & 64'h3;
            default: ;
        endcase
        cfg.valid <= 1'b0;
    endtask

    task automatic set_region(longint l, longint b, longint r, longint t, longint p,
                              longint f);
        wait_idle();
        write_reg(CFG_LEFT, l);
        write_reg(CFG_BOTTOM, b);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_TOP, t);
        write_reg(CFG_PITCH, p);
        write_reg(CFG_FILTER, f);
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_ADD;
        req.cell_left = '0;
        req.cell_bottom = '0;
        req.cell_width = '0;
        req.cell_height = '0;
        req.cell_kind = KIND_MACRO;
        req.bin_row = '0;
        req.bin_col = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_LEFT;
        cfg.data = '0;
        errors = 0;
        n_adds = 0;
        n_reads = 0;
        n_clears = 0;
        n_odd = 0;
        n_checked = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        hold_asks = 0;
        hold_served = 0;
        reg_left = 0;
        reg_bottom = 0;
        reg_right = 0;
        reg_top = 0;
        reg_pitch = 1;
        reg_filter = 0;
        foreach (area_store[i])
            area_store[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full 64x64 grid of pitch 10, reads before anything was added
        set_region(0, 0, 640, 640, 10, FILT_ALL);
        push_req(read_req(0, 0));
        push_req(read_req(63, 63));
        push_req(cell_req(I32_MIN, I32_MIN, I32_MAX, I32_MAX, KIND_MACRO));
        push_req(cell_req(5, 5, 0, 30, KIND_STD));   // zero width adds nothing
        push_req(cell_req(5, 5, 30, 0, KIND_STD));   // zero height adds nothing
        push_req(cell_req(3, 7, 25, 14, KIND_STD));
        push_req(cell_req(635, 635, 40, 40, 2));     // hangs off the top right
        push_req(cell_req(-20, -20, 25, 25, 3));     // hangs off the bottom left
        push_req(read_req(0, 0));
        push_req(read_req(0, 1));
        push_req(read_req(63, 63));
        push_req(read_req(0, 63));
        push_req(plain_req(2'd3));
        push_req(plain_req(REQ_CLEAR));
        push_req(read_req(0, 0));
        @(negedge clk);
        hold_asks++;
        push_random(120);

        // clipped edge bins, macros only, reads past the grid
        set_region(-37, 5, 100, 77, 16, FILT_MACRO);
        push_req(read_req(4, 8));
        push_req(read_req(5, 0));
        push_req(read_req(0, 9));
        push_random(90);

        // widest region and pitch, standard cells only
        set_region(I32_MIN, I32_MIN, I32_MAX, I32_MAX, 20'hF_FFFF, FILT_STD);
        push_req(cell_req(I32_MIN, I32_MIN, I32_MAX, I32_MAX, KIND_STD));
        push_req(cell_req(I32_MAX, I32_MAX, I32_MAX, I32_MAX, KIND_STD));
        push_req(read_req(0, 0));
        push_req(read_req(63, 63));
        push_random(90);

        // pitch zero acts as one; filter three passes nothing
        set_region(0, 0, 50, 30, 0, 3);
        push_random(50);

        // reversed span gives an empty grid
        set_region(100, 0, -100, 40, 7, FILT_ALL);
        push_random(30);

        // one big bin driven into sum saturation, then shrunk to area one
        set_region(0, 0, 20'hF_FFFF, 20'hF_FFFF, 20'hF_FFFF, FILT_ALL);
        push_req(plain_req(REQ_CLEAR));
        repeat (300)
            push_req(cell_req(0, 0, 20'hF_FFFF, 20'hF_FFFF, $urandom_range(0, 3)));
        push_req(read_req(0, 0));
        wait_idle();
        write_reg(CFG_PITCH, 1);
        push_req(read_req(0, 0));
        push_req(read_req(0, 1));

        // last stretch runs with neither side idling
        wait_idle();
        idle_on = 1'b0;
        set_region(0, 0, 320, 320, 5, FILT_ALL);
        push_random(110);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d adds, %0d reads, %0d clears, %0d unknown requests",
                 n_adds, n_reads, n_clears, n_odd);
        $display("over seven region setups incl. empty, clipped and saturating grids");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d errors, %0d results missing", errors, expected_rsps.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
